// File: hdl/fwc_pkg.sv
`timescale 1ns / 1ps
// shared types for the flash write-combining command encoder
// command and status structs between controller and datapath; no dependencies

package fwc_pkg;

    // where the datapath takes the next link byte from
    typedef enum logic [2:0] {
        SRC_CODE,
        SRC_START,
        SRC_COUNT,
        SRC_ADDR,
        SRC_VALUE,
        SRC_DELAY,
        SRC_LEN,
        SRC_DATA
    } src_t;

    // update of the device operation buffer fill count
    typedef enum logic [1:0] {
        USED_HOLD,
        USED_ADD5,
        USED_ADD_RUN,
        USED_CLEAR
    } used_op_t;

    // byte count used by the overflow check
    typedef enum logic [1:0] {
        CHK_5,
        CHK_6,
        CHK_RUN
    } chk_t;

    typedef struct packed {
        logic      load;
        logic      emit;
        src_t      src;
        logic [1:0] bsel;
        logic [7:0] code;
        logic      flush;
        logic      store_open;
        logic      store_append;
        logic      data_adv;
        logic      run_done;
        used_op_t  used_op;
        chk_t      chk;
    } cmd_t;

    typedef struct packed {
        logic [2:0] kind;
        logic       lim_zero;
        logic       lim_reached;
        logic       append_ok;
        logic       count_zero;
        logic       count_one;
        logic       data_last;
        logic       used_zero;
        logic       full;
        logic       emit_ok;
    } status_t;

endpackage

// File: hdl/flash_write_combining_command_encoder_top.sv
`timescale 1ns / 1ps
// top level of the flash write-combining command encoder
// instantiates fwc_ctrl and fwc_dp; depends on fwc_pkg

// Takes one host flash request at a time (write byte, delay, read byte,
// read n bytes, execute) and turns it into programmer command bytes, one byte
// per m_ transfer with m_tlast on the final byte of the request. Byte writes to
// consecutive addresses are collected into one buffered write-n command; the
// encoder tracks the device operation buffer and inserts an execute command
// before it would overflow. The link bytes of a request leave through a single
// byte-wide output path at one per cycle while m_tready is held high, and
// the controller also steps through dispatch, run bookkeeping and the buffer
// check. s_tready is high only between requests. A write that merely extends
// a run produces no bytes. No clearing pass runs after reset; the run buffer
// is only read at entries already written.

module flash_write_combining_command_encoder_top #(
    parameter int MAX_RUN = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,   // address[23:0], write_value[31:24],
                                   // delay_us[63:32], read_length[87:64]
    input  logic [2:0]  s_tuser,   // kind[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // link_byte[7:0]
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);

    fwc_pkg::cmd_t    cmd;
    fwc_pkg::status_t sts;

    fwc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    fwc_dp #(
        .MAX_RUN (MAX_RUN)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

// File: hdl/fwc_ram.sv
`timescale 1ns / 1ps
// generic single-write, single-read ram with registered read data
// no dependencies

module fwc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hdl/fwc_ctrl.sv
`timescale 1ns / 1ps
// controller: sequences requests into link bytes one step per cycle, holding while the output stalls
// depends on fwc_pkg (cmd_t, status_t and their enums)

module fwc_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  fwc_pkg::status_t sts,
    output fwc_pkg::cmd_t    cmd
);

    localparam logic [2:0] KIND_WRITE     = 3'd0;
    localparam logic [2:0] KIND_DELAY     = 3'd1;
    localparam logic [2:0] KIND_READ_BYTE = 3'd2;
    localparam logic [2:0] KIND_READ_N    = 3'd3;
    localparam logic [2:0] KIND_EXEC      = 3'd4;

    localparam logic [7:0] CMD_READ_BYTE  = 8'h09;
    localparam logic [7:0] CMD_READ_N     = 8'h0A;
    localparam logic [7:0] CMD_WRITE_BYTE = 8'h0C;
    localparam logic [7:0] CMD_WRITE_N    = 8'h0D;
    localparam logic [7:0] CMD_DELAY      = 8'h0E;
    localparam logic [7:0] CMD_EXEC       = 8'h0F;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_OPEN,
        S_CHK,
        S_EXEC,
        S_LIMCHK,
        S_CMD,
        S_RUN,
        S_FIN
    } state_t;

    state_t     state_reg, state_next;
    state_t     ret_reg, ret_next;
    logic [2:0] step_reg, step_next;
    logic       write_run;
    logic       in_data;

    assign write_run = (sts.kind == KIND_WRITE) && !sts.lim_zero;

    always_comb begin
        cmd         = '0;
        cmd.src     = fwc_pkg::SRC_CODE;
        cmd.used_op = fwc_pkg::USED_HOLD;
        cmd.chk     = fwc_pkg::CHK_5;
        state_next  = state_reg;
        ret_next    = ret_reg;
        step_next   = step_reg;
        s_tready    = 1'b0;
        in_data     = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end

            S_DISPATCH: begin
                step_next = 3'd0;
                case (sts.kind)
                    KIND_WRITE: begin
                        if (sts.lim_zero) begin
                            ret_next   = S_CHK;
                            state_next = S_RUN;
                        end else if (sts.append_ok) begin
                            cmd.store_append = 1'b1;
                            state_next       = S_CHK;
                        end else begin
                            ret_next   = S_OPEN;
                            state_next = S_RUN;
                        end
                    end
                    KIND_DELAY: begin
                        ret_next   = S_CHK;
                        state_next = S_RUN;
                    end
                    KIND_READ_BYTE, KIND_READ_N: begin
                        // a read drains everything queued in the device first
                        if (!sts.used_zero || !sts.count_zero) begin
                            ret_next   = S_EXEC;
                            state_next = S_RUN;
                        end else begin
                            state_next = S_CMD;
                        end
                    end
                    KIND_EXEC: begin
                        ret_next   = S_EXEC;
                        state_next = S_RUN;
                    end
                    default: state_next = S_FIN;
                endcase
            end

            S_OPEN: begin
                cmd.store_open = 1'b1;
                state_next     = S_CHK;
            end

            S_CHK: begin
                if (write_run) begin
                    cmd.chk = fwc_pkg::CHK_RUN;
                end else if (sts.kind == KIND_WRITE) begin
                    cmd.chk = fwc_pkg::CHK_6;
                end else begin
                    cmd.chk = fwc_pkg::CHK_5;
                end
                step_next = 3'd0;
                if (sts.full) begin
                    ret_next   = S_EXEC;
                    state_next = S_RUN;
                end else if (write_run) begin
                    state_next = S_LIMCHK;
                end else begin
                    state_next = S_CMD;
                end
            end

            S_EXEC: begin
                if (sts.emit_ok) begin
                    cmd.emit    = 1'b1;
                    cmd.code    = CMD_EXEC;
                    cmd.used_op = fwc_pkg::USED_CLEAR;
                    step_next   = 3'd0;
                    if (sts.kind == KIND_EXEC) begin
                        state_next = S_FIN;
                    end else if (write_run) begin
                        state_next = S_LIMCHK;
                    end else begin
                        state_next = S_CMD;
                    end
                end
            end

            S_LIMCHK: begin
                step_next = 3'd0;
                if (sts.lim_reached) begin
                    ret_next   = S_FIN;
                    state_next = S_RUN;
                end else begin
                    state_next = S_FIN;
                end
            end

            S_CMD: begin
                if (sts.emit_ok) begin
                    cmd.emit  = 1'b1;
                    step_next = step_reg + 3'd1;
                    case (sts.kind)
                        KIND_WRITE: begin
                            if (step_reg == 3'd0) begin
                                cmd.code = CMD_WRITE_BYTE;
                            end else if (step_reg < 3'd4) begin
                                cmd.src  = fwc_pkg::SRC_ADDR;
                                cmd.bsel = 2'(step_reg - 3'd1);
                            end else begin
                                cmd.src     = fwc_pkg::SRC_VALUE;
                                cmd.used_op = fwc_pkg::USED_ADD5;
                                state_next  = S_FIN;
                            end
                        end
                        KIND_DELAY: begin
                            if (step_reg == 3'd0) begin
                                cmd.code = CMD_DELAY;
                            end else begin
                                cmd.src  = fwc_pkg::SRC_DELAY;
                                cmd.bsel = 2'(step_reg - 3'd1);
                                if (step_reg == 3'd4) begin
                                    cmd.used_op = fwc_pkg::USED_ADD5;
                                    state_next  = S_FIN;
                                end
                            end
                        end
                        KIND_READ_BYTE: begin
                            if (step_reg == 3'd0) begin
                                cmd.code = CMD_READ_BYTE;
                            end else begin
                                cmd.src  = fwc_pkg::SRC_ADDR;
                                cmd.bsel = 2'(step_reg - 3'd1);
                                if (step_reg == 3'd3) begin
                                    state_next = S_FIN;
                                end
                            end
                        end
                        KIND_READ_N: begin
                            if (step_reg == 3'd0) begin
                                cmd.code = CMD_READ_N;
                            end else if (step_reg < 3'd4) begin
                                cmd.src  = fwc_pkg::SRC_ADDR;
                                cmd.bsel = 2'(step_reg - 3'd1);
                            end else begin
                                cmd.src  = fwc_pkg::SRC_LEN;
                                cmd.bsel = 2'(step_reg - 3'd4);
                                if (step_reg == 3'd6) begin
                                    state_next = S_FIN;
                                end
                            end
                        end
                        default: begin
                            cmd.emit   = 1'b0;
                            state_next = S_FIN;
                        end
                    endcase
                end
            end

            S_RUN: begin
                // an empty run sends nothing and just returns
                if (sts.count_zero) begin
                    state_next = ret_reg;
                end else if (sts.emit_ok) begin
                    cmd.emit = 1'b1;
                    in_data  = sts.count_one ? (step_reg == 3'd4) : (step_reg == 3'd7);
                    if (step_reg == 3'd0) begin
                        cmd.code = sts.count_one ? CMD_WRITE_BYTE : CMD_WRITE_N;
                    end else if (in_data) begin
                        cmd.src = fwc_pkg::SRC_DATA;
                    end else if (sts.count_one || step_reg >= 3'd4) begin
                        cmd.src  = fwc_pkg::SRC_START;
                        cmd.bsel = sts.count_one ? 2'(step_reg - 3'd1)
                                                 : 2'(step_reg - 3'd4);
                    end else begin
                        cmd.src  = fwc_pkg::SRC_COUNT;
                        cmd.bsel = 2'(step_reg - 3'd1);
                    end
                    if (in_data) begin
                        cmd.data_adv = 1'b1;
                        if (sts.data_last) begin
                            cmd.run_done = 1'b1;
                            cmd.used_op  = fwc_pkg::USED_ADD_RUN;
                            state_next   = ret_reg;
                        end
                    end else begin
                        step_next = step_reg + 3'd1;
                    end
                end
            end

            S_FIN: begin
                // hold back the final byte until it can go out marked last
                if (sts.emit_ok) begin
                    cmd.flush  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ret_reg   <= S_FIN;
            step_reg  <= 3'd0;
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            step_reg  <= step_next;
        end
    end

endmodule

// File: hdl/fwc_dp.sv
`timescale 1ns / 1ps
// datapath: config registers, request fields, pending run, buffer fill count,
// link byte selection and the output stage; depends on fwc_pkg and fwc_ram

module fwc_dp #(
    parameter int MAX_RUN = 32
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [87:0]      s_tdata,
    input  logic [2:0]       s_tuser,
    input  logic             cfg_we,
    input  logic [0:0]       cfg_addr,
    input  logic [15:0]      cfg_wdata,
    output logic [7:0]       m_tdata,
    output logic             m_tlast,
    output logic             m_tvalid,
    input  logic             m_tready,
    input  fwc_pkg::cmd_t    cmd,
    output fwc_pkg::status_t sts
);

    localparam int CNT_W = $clog2(MAX_RUN + 1);
    localparam int IDX_W = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;
    localparam int CMP_W = ((CNT_W > 6) ? CNT_W : 6) + 1;
    localparam int N_W   = $clog2(MAX_RUN + 8);

    localparam logic [0:0]  REG_RUN_LIMIT  = 1'b0;
    localparam logic [0:0]  REG_OPBUF_CAP  = 1'b1;
    localparam logic [15:0] OPBUF_CAP_INIT = 16'd300;
    localparam logic [16:0] USED_MAX       = 17'h1FFFF;

    logic [5:0]       limit_reg;
    logic [15:0]      cap_reg;
    logic [2:0]       kind_reg;
    logic [23:0]      addr_reg;
    logic [7:0]       value_reg;
    logic [31:0]      delay_reg;
    logic [23:0]      len_reg;
    logic [23:0]      start_reg;
    logic [CNT_W-1:0] count_reg;
    logic [16:0]      used_reg;
    logic [IDX_W-1:0] ridx_reg, ridx_next;
    logic [7:0]       hold_reg;
    logic             hold_valid_reg;
    logic [7:0]       out_data_reg;
    logic             out_last_reg;
    logic             out_valid_reg;

    logic [CMP_W-1:0] lim_eff;
    logic [N_W-1:0]   run_n;
    logic [N_W-1:0]   chk_n;
    logic [N_W-1:0]   add_n;
    logic [17:0]      chk_sum;
    logic [17:0]      used_sum;
    logic [16:0]      used_sat;
    logic [31:0]      word;
    logic [7:0]       link_byte;
    logic [7:0]       ram_rdata;
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;

    assign lim_eff = (CMP_W'(limit_reg) > CMP_W'(MAX_RUN)) ? CMP_W'(MAX_RUN)
                                                           : CMP_W'(limit_reg);

    // a run of one byte goes out as a write-byte command, five bytes in the device
    assign run_n = (count_reg == CNT_W'(1)) ? N_W'(5) : N_W'(7) + N_W'(count_reg);

    always_comb begin
        case (cmd.chk)
            fwc_pkg::CHK_6:   chk_n = N_W'(6);
            fwc_pkg::CHK_RUN: chk_n = N_W'(7) + N_W'(count_reg);
            default:          chk_n = N_W'(5);
        endcase
    end

    assign chk_sum = 18'(used_reg) + 18'(chk_n);

    assign add_n    = (cmd.used_op == fwc_pkg::USED_ADD_RUN) ? run_n : N_W'(5);
    assign used_sum = 18'(used_reg) + 18'(add_n);
    assign used_sat = (used_sum > 18'(USED_MAX)) ? USED_MAX : used_sum[16:0];

    assign sts.kind        = kind_reg;
    assign sts.lim_zero    = (lim_eff == '0);
    assign sts.lim_reached = (CMP_W'(count_reg) >= lim_eff);
    assign sts.append_ok   = (count_reg != '0) && (count_reg < CNT_W'(MAX_RUN))
                           && (addr_reg == start_reg + 24'(count_reg));
    assign sts.count_zero  = (count_reg == '0);
    assign sts.count_one   = (count_reg == CNT_W'(1));
    assign sts.data_last   = (CNT_W'(ridx_reg) + CNT_W'(1) == count_reg);
    assign sts.used_zero   = (used_reg == '0);
    assign sts.full        = (18'(cap_reg) <= chk_sum);
    assign sts.emit_ok     = !hold_valid_reg || !out_valid_reg || m_tready;

    // byte select over the multi-byte fields, least significant byte first
    always_comb begin
        case (cmd.src)
            fwc_pkg::SRC_START: word = {8'd0, start_reg};
            fwc_pkg::SRC_COUNT: word = 32'(count_reg);
            fwc_pkg::SRC_ADDR:  word = {8'd0, addr_reg};
            fwc_pkg::SRC_DELAY: word = delay_reg;
            fwc_pkg::SRC_LEN:   word = {8'd0, len_reg};
            default:            word = 32'd0;
        endcase
    end

    always_comb begin
        case (cmd.src)
            fwc_pkg::SRC_CODE:  link_byte = cmd.code;
            fwc_pkg::SRC_VALUE: link_byte = value_reg;
            fwc_pkg::SRC_DATA:  link_byte = ram_rdata;
            default:            link_byte = word[{cmd.bsel, 3'b000} +: 8];
        endcase
    end

    // read address runs one step ahead so the data byte is ready when needed
    always_comb begin
        if (cmd.run_done) begin
            ridx_next = '0;
        end else if (cmd.data_adv) begin
            ridx_next = ridx_reg + IDX_W'(1);
        end else begin
            ridx_next = ridx_reg;
        end
    end

    assign ram_we    = cmd.store_open || cmd.store_append;
    assign ram_waddr = cmd.store_open ? '0 : count_reg[IDX_W-1:0];

    fwc_ram #(
        .WIDTH (8),
        .DEPTH (MAX_RUN)
    ) u_run_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (value_reg),
        .raddr (ridx_next),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg  <= s_tuser;
            addr_reg  <= s_tdata[23:0];
            value_reg <= s_tdata[31:24];
            delay_reg <= s_tdata[63:32];
            len_reg   <= s_tdata[87:64];
        end
        if (cmd.store_open) begin
            start_reg <= addr_reg;
        end
        if (cmd.emit) begin
            hold_reg <= link_byte;
        end
        // only a held byte moves on; a stalled output byte stays put
        if ((cmd.emit || cmd.flush) && hold_valid_reg) begin
            out_data_reg <= hold_reg;
            out_last_reg <= cmd.flush;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg      <= 6'd0;
            cap_reg        <= OPBUF_CAP_INIT;
            count_reg      <= '0;
            used_reg       <= 17'd0;
            ridx_reg       <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_addr)
                    REG_RUN_LIMIT: limit_reg <= cfg_wdata[5:0];
                    REG_OPBUF_CAP: cap_reg   <= cfg_wdata;
                endcase
            end

            if (cmd.run_done) begin
                count_reg <= '0;
            end else if (cmd.store_open) begin
                count_reg <= CNT_W'(1);
            end else if (cmd.store_append) begin
                count_reg <= count_reg + CNT_W'(1);
            end

            case (cmd.used_op) inside
                fwc_pkg::USED_ADD5, fwc_pkg::USED_ADD_RUN: used_reg <= used_sat;
                fwc_pkg::USED_CLEAR:                       used_reg <= 17'd0;
                default:                                   used_reg <= used_reg;
            endcase

            ridx_reg <= ridx_next;

            // held byte moves to the output stage when a newer byte arrives or the request is flushed
            if ((cmd.emit || cmd.flush) && hold_valid_reg) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.emit) begin
                hold_valid_reg <= 1'b1;
            end else if (cmd.flush) begin
                hold_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tvalid = out_valid_reg;

endmodule

// File: hdl/fwc_checker.sv
`timescale 1ns / 1ps
// port-level checks for the flash write-combining command encoder
// bound to flash_write_combining_command_encoder_top; no package use

module fwc_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    // output stage empties on reset
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // one request in flight: no second transfer in the following cycle
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken twice in a row");

    // while waiting for a request, only the final byte of the last one may remain
    a_idle_only_last: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready && m_tvalid |-> m_tlast)
        else $error("non-final byte pending while ready for input");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

endmodule

bind flash_write_combining_command_encoder_top fwc_checker u_fwc_checker (.*);
